// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("implication check failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("next-cycle check failed");

// next-cycle implication, always active
`define ASSERT_NXT_ALWAYS(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |=> (c)) \
    else $error("reset check failed");

`endif

// File: sv/stg_pkg.sv
package stg_pkg;

  localparam int TABLE_ADDR_BITS = 10;
  localparam int OUT_BITS        = 16;
  localparam int PERIOD_BITS     = 24;

  localparam int TBL_N    = 1 << TABLE_ADDR_BITS;
  localparam int TAB_AW   = TABLE_ADDR_BITS + 1;
  localparam int MAG_BITS = OUT_BITS - 1;
  localparam int STEP_BITS = 31;
  localparam int PHASE_BITS = 32;

  localparam logic [STEP_BITS-1:0]   STEP_RST   = 31'd44739243;
  localparam logic [PHASE_BITS-1:0]  OFFSET_RST = 32'd0;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RST = PERIOD_BITS'(96);

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] REG_PHASE_OFFSET = 2'd1;
  localparam logic [1:0] REG_PERIOD       = 2'd2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned AMP = (64'd1 << MAG_BITS) - 64'd1;
  localparam longint unsigned SER_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [MAG_BITS-1:0] mag_t;
  typedef mag_t tab_t [0:TBL_N];

  function automatic tab_t build_tab();
    tab_t t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    for (int i = 0; i <= TBL_N; i++) begin
      x = (HALF_PI_Q30 * longint'(i)) >> TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        term = term / SER_DIV[k];
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * AMP + (64'd1 << 29)) >> 30;
      if (v > AMP) begin
        v = AMP;
      end
      t[i] = MAG_BITS'(v);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

endpackage

// File: sv/sine_tone_generator_with_sync_core.sv
// path from input transaction to result valid: table read register, then output register
// throughput: one transaction per cycle while the output is not stalled, set by the registered quarter-wave rom read
// input is stalled only while both the rom stage and the output register are held
// reset (rst_n low, synchronous): pipeline emptied, position, accumulator and sync cleared
// reset also restores the configuration registers to their default values
module sine_tone_generator_with_sync_core import stg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_block_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] out_sample,
  output logic                out_sync_mark,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [STEP_BITS-1:0]   step_r;
  logic [PHASE_BITS-1:0]  offset_r;
  logic [PERIOD_BITS-1:0] period_r;

  logic [PERIOD_BITS-1:0] pos_r, pos_nxt;
  logic [PHASE_BITS-1:0]  acc_r, acc_nxt;
  logic                   seen_r, seen_nxt;

  logic                   s1_valid_r;
  mag_t                   s1_mag_r;
  logic                   s1_neg_r;
  logic                   s1_mark_r;

  logic                   out_valid_r;
  logic [OUT_BITS-1:0]    out_sample_r;
  logic                   out_mark_r;

  logic                   adv_out;
  logic                   adv_s1;
  logic                   in_acc;
  logic                   cfg_wr;

  logic [PHASE_BITS-1:0]  ph;
  logic [TABLE_ADDR_BITS-1:0] k_idx;
  logic [TAB_AW-1:0]      tab_addr;
  logic                   seen_eff;
  logic                   mark;
  logic [PERIOD_BITS:0]   pos_inc;
  logic                   wrap;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RST;
      offset_r <= OFFSET_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PHASE_STEP:   step_r   <= pwdata[STEP_BITS-1:0];
        REG_PHASE_OFFSET: offset_r <= pwdata[PHASE_BITS-1:0];
        REG_PERIOD:       period_r <= pwdata[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PHASE_STEP:   prdata = 32'(step_r);
      REG_PHASE_OFFSET: prdata = 32'(offset_r);
      REG_PERIOD:       prdata = 32'(period_r);
      default:          prdata = 32'd0;
    endcase
  end

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_s1   = !s1_valid_r || adv_out;
  assign in_stall = !adv_s1;
  assign in_acc   = in_valid && adv_s1;

  always_comb begin
    ph       = acc_r + offset_r;
    k_idx    = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    tab_addr = ph[PHASE_BITS-2] ? (TAB_AW'(TBL_N) - {1'b0, k_idx}) : {1'b0, k_idx};
    seen_eff = in_block_start ? 1'b0 : seen_r;
    mark     = (pos_r == '0) && !seen_eff;
    seen_nxt = seen_eff | mark;
    pos_inc  = {1'b0, pos_r} + (PERIOD_BITS+1)'(1);
    wrap     = pos_inc >= {1'b0, period_r};
    pos_nxt  = wrap ? '0 : pos_inc[PERIOD_BITS-1:0];
    acc_nxt  = wrap ? '0 : acc_r + PHASE_BITS'(step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      acc_r  <= '0;
      seen_r <= 1'b0;
    end else if (in_acc) begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
    end
  end

  // quarter-wave rom with registered read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mag_r  <= SINE_TAB[tab_addr];
      s1_neg_r  <= ph[PHASE_BITS-1];
      s1_mark_r <= mark;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_sample_r <= s1_neg_r ? (OUT_BITS'(0) - {1'b0, s1_mag_r}) : {1'b0, s1_mag_r};
      out_mark_r   <= s1_mark_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_sync_mark = out_mark_r;

endmodule

// File: sv/stg_checker.sv
`include "assert_macros.svh"

module stg_checker import stg_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [OUT_BITS-1:0] out_sample,
  input logic                out_sync_mark
);

  logic held;
  logic full_scale_neg;

  assign held = out_valid && out_stall;
  assign full_scale_neg = out_sample == {1'b1, {(OUT_BITS-1){1'b0}}};

  // a held result keeps its payload
  `ASSERT_NXT(a_out_hold, clk, rst_n, held, out_valid && $stable(out_sample) && $stable(out_sync_mark))

  // input is only stalled when the result side is backed up
  `ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // no transaction leaves the block right after reset
  `ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // table magnitude never reaches the negative full-scale code
  `ASSERT_IMP(a_no_neg_full, clk, rst_n, out_valid && in_valid, !full_scale_neg)

endmodule

bind sine_tone_generator_with_sync_core stg_checker u_stg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sample    (out_sample),
  .out_sync_mark (out_sync_mark)
);

// File: tb/tb_sine_tone_generator_with_sync_core.sv
module tb_sine_tone_generator_with_sync_core;
  import stg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_PRINTS     = 40;

  typedef struct {
    logic [OUT_BITS-1:0] sample;
    logic                sync_mark;
  } tone_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_block_start;
  logic out_valid;
  logic out_stall;
  logic [OUT_BITS-1:0] out_sample;
  logic out_sync_mark;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [MAG_BITS-1:0] quarter_wave [0:TBL_N];
  logic [STEP_BITS-1:0] reg_step;
  logic [PHASE_BITS-1:0] reg_offset;
  logic [PERIOD_BITS-1:0] reg_period;
  logic [PERIOD_BITS-1:0] tone_pos;
  logic [PHASE_BITS-1:0] tone_acc;
  logic sync_taken;

  tone_t expected_tones [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold_req = 1'b0;

  sine_tone_generator_with_sync_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_block_start(in_block_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample),
    .out_sync_mark(out_sync_mark),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [MAG_BITS-1:0] quarter_mag(input int unsigned i);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned series;
    longint unsigned scaled;
    ang = (HALF_PI_Q30 * longint'(i)) >> TABLE_ADDR_BITS;
    ang_sq = (ang * ang) >> 30;
    term = ang;
    series = ang;
    for (int k = 1; k <= 8; k++) begin
      term = (term * ang_sq) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        series = series - term;
      end else begin
        series = series + term;
      end
    end
    scaled = (series * AMP + (64'd1 << 29)) >> 30;
    if (scaled > AMP) begin
      scaled = AMP;
    end
    return MAG_BITS'(scaled);
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch %0s: got %0d expected %0d", what, got, want);
    end
    mismatches++;
  endtask

  task automatic predict_tone(input logic start);
    logic [PHASE_BITS-1:0] ph;
    logic [1:0] quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [MAG_BITS-1:0] mag;
    logic [PERIOD_BITS:0] next_pos;
    logic [PERIOD_BITS:0] span;
    tone_t t;
    ph = tone_acc + reg_offset;
    quad = ph[PHASE_BITS-1 -: 2];
    idx = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    mag = quad[0] ? quarter_wave[TBL_N - int'(idx)] : quarter_wave[idx];
    t.sample = quad[1] ? -{1'b0, mag} : {1'b0, mag};
    if (start) begin
      sync_taken = 1'b0;
    end
    t.sync_mark = (tone_pos == '0) && !sync_taken;
    if (t.sync_mark) begin
      sync_taken = 1'b1;
    end
    span = (reg_period == '0) ? (PERIOD_BITS+1)'(1) : {1'b0, reg_period};
    next_pos = {1'b0, tone_pos} + 1'b1;
    if (next_pos >= span) begin
      tone_pos = '0;
      tone_acc = '0;
    end else begin
      tone_pos = next_pos[PERIOD_BITS-1:0];
      tone_acc = tone_acc + {1'b0, reg_step};
    end
    expected_tones.push_back(t);
  endtask

  task automatic send_item(input logic start);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_block_start <= start;
    do @(posedge clk); while (in_stall);
    predict_tone(start);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_tones.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PHASE_STEP: begin
        reg_step = val[STEP_BITS-1:0];
        want = 32'(reg_step);
      end
      REG_PHASE_OFFSET: begin
        reg_offset = val;
        want = reg_offset;
      end
      default: begin
        reg_period = val[PERIOD_BITS-1:0];
        want = 32'(reg_period);
      end
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      report_mismatch($sformatf("readback of register %0d", idx), prdata, want);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tone(input logic [31:0] step, input logic [31:0] offset,
                          input logic [31:0] period);
    wait_idle();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_PHASE_OFFSET, offset);
    write_reg(REG_PERIOD, period);
  endtask

  task automatic test_reset_values();
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
  endtask

  task automatic test_period_corners();
    set_tone(32'd44739243, 32'd0, 32'd1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    // zero period behaves as one
    set_tone(32'd44739243, 32'd0, 32'd0);
    send_item(1'b0);
    send_item(1'b1);
    set_tone(32'd1000000, 32'd0, 32'd8);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    // period cut below the current position
    set_tone(32'd1000000, 32'd0, 32'd3);
    send_item(1'b0);
    send_item(1'b0);
  endtask

  task automatic test_phase_corners();
    // frozen phase at the top offset
    set_tone(32'd0, 32'hFFFF_FFFF, 32'hFF_FFFF);
    send_item(1'b1);
    send_item(1'b0);
    // one quarter turn per sample walks through all quadrants
    set_tone(32'h4000_0000, 32'd0, 32'hFF_FFFF);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    set_tone(32'h7FFF_FFFF, 32'h3FF0_0000, 32'hFF_FFFF);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_backpressure();
    set_tone($urandom, $urandom, $urandom_range(2, 50));
    tx_calm = 1'b1;
    rx_hold_req = 1'b1;
    send_item(1'b1);
    repeat (39) send_item($urandom_range(0, 9) == 0);
    tx_calm = 1'b0;
  endtask

  task automatic test_random_tones();
    logic [31:0] step;
    logic [31:0] offset;
    logic [31:0] period;
    for (int chunk = 0; chunk < 16; chunk++) begin
      case ($urandom_range(0, 4))
        0: step = 32'd0;
        1: step = 32'd1;
        2: step = 32'h7FFF_FFFF;
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: offset = 32'd0;
        1: offset = 32'hFFFF_FFFF;
        default: offset = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: period = 32'd0;
        1: period = 32'd1;
        2: period = 32'hFF_FFFF;
        3: period = $urandom;
        4, 5, 6: period = $urandom_range(2, 8);
        default: period = $urandom_range(9, 200);
      endcase
      set_tone(step, offset, period);
      tx_calm = (chunk % 4 == 1);
      rx_calm = (chunk % 4 == 2);
      send_item(1'b1);
      repeat (49) send_item($urandom_range(0, 9) == 0);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  always @(posedge clk) begin
    tone_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tones.size() == 0) begin
        report_mismatch("unexpected sample", $signed(out_sample), 0);
      end else begin
        t = expected_tones.pop_front();
        if (out_sample !== t.sample) begin
          report_mismatch("sample", $signed(out_sample), $signed(t.sample));
        end
        if (out_sync_mark !== t.sync_mark) begin
          report_mismatch("sync_mark", out_sync_mark, t.sync_mark);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sine_tone_generator_with_sync_core test failed");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        rx_hold_req = 1'b0;
      end else begin
        n = pick_gap(rx_calm);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_block_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int i = 0; i <= TBL_N; i++) begin
      quarter_wave[i] = quarter_mag(i);
    end
    reg_step = STEP_RST;
    reg_offset = OFFSET_RST;
    reg_period = PERIOD_RST;
    tone_pos = '0;
    tone_acc = '0;
    sync_taken = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_period_corners();
    test_phase_corners();
    test_backpressure();
    test_random_tones();
    wait_idle();
    if (mismatches == 0) begin
      $display("sine_tone_generator_with_sync_core test passed");
    end else begin
      $display("sine_tone_generator_with_sync_core test failed");
    end
    $finish;
  end

endmodule
